@@ hdl/rrpa_pkg.sv @@
package rrpa_pkg;

  localparam int NUM_SOURCES_DEF = 8;

  localparam int HAS_W   = 8;
  localparam int IDX_W   = 3;
  localparam int IN_DW   = 16;
  localparam int OUT_DW  = 8;

  localparam logic MODE_PULL    = 1'b0;
  localparam logic MODE_UNBLOCK = 1'b1;

  typedef struct packed {
    logic             wakeup;
    logic             underrun;
    logic [IDX_W-1:0] grant_index;
    logic             granted;
  } result_t;

endpackage

@@ hdl/round_robin_pull_arbiter_core.sv @@
// Channel  Dir  tdata                                   tuser
// s_axis   in   [7:0] source_has_data, [10:8] unblock_index, mode
//                [15:11] zero
// m_axis   out  [0] granted, [3:1] grant_index,         -
//                [4] underrun, [5] wakeup, [7:6] zero
//
// One transfer in, one result out; a new transfer every cycle while the
// result is taken. The input is registered, then the rotating priority
// encode over the blocked marks feeds the result register.
// Reset clears the marks, the pointer, the waiting flag and both valids.
// A stalled result holds the input register; the input is taken again once
// the result register frees.
module round_robin_pull_arbiter_core
  import rrpa_pkg::*;
#(
  parameter int NumSources = NUM_SOURCES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [IN_DW-1:0]  s_axis_tdata,   // source_has_data, unblock_index
  input  logic              s_axis_tuser,   // mode
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_DW-1:0] m_axis_tdata    // granted, grant_index, underrun, wakeup
);

  localparam int PtrW = $clog2(NumSources);
  localparam logic [PtrW:0] NsW = (PtrW+1)'(NumSources);
  localparam logic [NumSources-1:0] AllOnes = '1;
  localparam logic [NumSources-1:0] OneHot0 = {{(NumSources-1){1'b0}}, 1'b1};

  logic                   in_valid_q;
  logic                   mode_q;
  logic [HAS_W-1:0]       has_raw_q;
  logic [IDX_W-1:0]       unb_idx_q;

  logic [NumSources-1:0]  blocked_q, blocked_d;
  logic [PtrW-1:0]        ptr_q, ptr_d;
  logic                   waiting_q, waiting_d;

  logic                   out_valid_q;
  result_t                res_q, res_d;

  logic                   fire;
  logic [NumSources-1:0]  has;
  logic [NumSources-1:0]  rot_blk, rot_has, rot_cand, rot_unb, low_mask, rot_new;
  logic [2*NumSources-1:0] dbl_blk, dbl_has, dbl_back;
  logic [PtrW-1:0]        first_j, last_k;
  logic                   found;
  logic [PtrW:0]          sum_g, sum_after_g, sum_after_k;
  logic [PtrW:0]          g_mod, after_g_mod, after_k_mod;

  assign fire          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DW-$bits(result_t)){1'b0}}, res_q};

  for (genvar gi = 0; gi < NumSources; gi++) begin : g_has
    if (gi < HAS_W) begin : g_in
      assign has[gi] = has_raw_q[gi];
    end else begin : g_out
      assign has[gi] = 1'b0;
    end
  end

  always_comb begin
    dbl_blk  = {blocked_q, blocked_q} >> ptr_q;
    dbl_has  = {has, has} >> ptr_q;
    rot_blk  = dbl_blk[NumSources-1:0];
    rot_has  = dbl_has[NumSources-1:0];
    rot_unb  = ~rot_blk;
    rot_cand = rot_unb & rot_has;
    found    = |rot_cand;

    first_j = '0;
    for (int i = NumSources - 1; i >= 0; i--) begin
      if (rot_cand[i]) first_j = PtrW'(i);
    end
    last_k = '0;
    for (int i = 0; i < NumSources; i++) begin
      if (rot_unb[i]) last_k = PtrW'(i);
    end
    for (int i = 0; i < NumSources; i++) begin
      low_mask[i] = (PtrW'(i) < first_j);
    end

    rot_new  = rot_blk | low_mask;
    dbl_back = {rot_new, rot_new} << ptr_q;

    sum_g       = {1'b0, ptr_q} + {1'b0, first_j};
    g_mod       = (sum_g >= NsW) ? sum_g - NsW : sum_g;
    sum_after_g = g_mod + (PtrW+1)'(1);
    after_g_mod = (sum_after_g >= NsW) ? sum_after_g - NsW : sum_after_g;
    sum_after_k = {1'b0, ptr_q} + {1'b0, last_k} + (PtrW+1)'(1);
    after_k_mod = (sum_after_k >= NsW) ? sum_after_k - NsW : sum_after_k;

    blocked_d = blocked_q;
    ptr_d     = ptr_q;
    waiting_d = waiting_q;
    res_d     = '0;

    case (mode_q)
      MODE_UNBLOCK: begin
        blocked_d = blocked_q & ~(OneHot0 << unb_idx_q);
        if (waiting_q) begin
          res_d.wakeup = 1'b1;
          waiting_d    = 1'b0;
        end
      end
      MODE_PULL: begin
        if (blocked_q == AllOnes) begin
          res_d.underrun = 1'b1;
          waiting_d      = 1'b1;
        end else if (found) begin
          res_d.granted     = 1'b1;
          res_d.grant_index = IDX_W'(g_mod);
          blocked_d         = dbl_back[2*NumSources-1:NumSources];
          ptr_d             = after_g_mod[PtrW-1:0];
        end else begin
          res_d.underrun = 1'b1;
          waiting_d      = 1'b1;
          blocked_d      = AllOnes;
          ptr_d          = after_k_mod[PtrW-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      blocked_q   <= '0;
      ptr_q       <= '0;
      waiting_q   <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (fire) begin
        out_valid_q <= 1'b1;
        blocked_q   <= blocked_d;
        ptr_q       <= ptr_d;
        waiting_q   <= waiting_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      mode_q    <= s_axis_tuser;
      has_raw_q <= s_axis_tdata[HAS_W-1:0];
      unb_idx_q <= s_axis_tdata[HAS_W+IDX_W-1:HAS_W];
    end
    if (fire) res_q <= res_d;
  end

endmodule
